// ===== src/pds_pkg.sv =====
// Shared constants, types and the microcode table for the differential steering core.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package pds_pkg;

    // Field and arithmetic widths.
    localparam int ERROR_WIDTH    = 8;
    localparam int SUM_WIDTH      = 24;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int LEVEL_LIMIT    = 4;
    localparam int GAIN_W         = 16;
    localparam int LEVEL_W        = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int DIFF_W         = ERROR_WIDTH + 1;

    // Multiplier operand B must hold the integral, the difference and the level.
    localparam int MUL_B_W = (SUM_WIDTH > DIFF_W) ? SUM_WIDTH : DIFF_W;
    localparam int PROD_W  = GAIN_W + 1 + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    // Wheel arithmetic: base plus level times step never exceeds this width.
    localparam int SPD_W   = GAIN_W + LEVEL_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd10240;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd41;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 16'd4096;
    localparam logic [GAIN_W-1:0] RST_BASE_SPEED = 16'd20000;
    localparam logic [GAIN_W-1:0] RST_SPEED_STEP = 16'd5000;
    localparam logic [GAIN_W-1:0] RST_MAX_SPEED  = 16'd65535;

    // Microprogram address width and step count.
    localparam int UPC_W = 3;

    typedef enum logic [1:0] {
        A_PROP,
        A_INTEG,
        A_DERIV,
        A_STEP
    } a_sel_t;

    typedef enum logic [1:0] {
        B_ERROR,
        B_SUM,
        B_DIFF,
        B_LEVEL
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        a_sel_t             a_sel;
        b_sel_t             b_sel;
        logic               mul_en;
        acc_op_t            acc_op;
        logic               level_en;
        logic               finish;
        cond_t              cond;
        logic [UPC_W-1:0]   next_addr;
    } ctrl_word_t;

    // Program: wait for a beat, three gain products summed, level, speed product, finish.
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] addr);
        ctrl_word_t w;
        w = '{a_sel: A_PROP, b_sel: B_ERROR, mul_en: 1'b0, acc_op: ACC_HOLD,
              level_en: 1'b0, finish: 1'b0, cond: COND_ALWAYS, next_addr: '0};
        unique case (addr)
            3'd0: begin
                w.cond      = COND_IN_BEAT;
                w.next_addr = 3'd1;
            end
            3'd1: begin
                w.a_sel     = A_PROP;
                w.b_sel     = B_ERROR;
                w.mul_en    = 1'b1;
                w.next_addr = 3'd2;
            end
            3'd2: begin
                w.a_sel     = A_INTEG;
                w.b_sel     = B_SUM;
                w.mul_en    = 1'b1;
                w.acc_op    = ACC_LOAD;
                w.next_addr = 3'd3;
            end
            3'd3: begin
                w.a_sel     = A_DERIV;
                w.b_sel     = B_DIFF;
                w.mul_en    = 1'b1;
                w.acc_op    = ACC_ADD;
                w.next_addr = 3'd4;
            end
            3'd4: begin
                w.acc_op    = ACC_ADD;
                w.next_addr = 3'd5;
            end
            3'd5: begin
                w.level_en  = 1'b1;
                w.next_addr = 3'd6;
            end
            3'd6: begin
                w.a_sel     = A_STEP;
                w.b_sel     = B_LEVEL;
                w.mul_en    = 1'b1;
                w.next_addr = 3'd7;
            end
            3'd7: begin
                w.finish    = 1'b1;
                w.cond      = COND_OUT_FREE;
                w.next_addr = 3'd0;
            end
            default: begin
                w.next_addr = '0;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/pid_differential_steering_core.sv =====
// Top level of the PID differential steering core: sequencer, datapath and registers.
// Depends on pds_pkg for widths, control word type and the microcode table.
`default_nettype none

// One error beat in, one wheel-speed beat out. The core works on one sample at a
// time: a beat is taken in the idle step, and its result lands in the output
// register when the last step completes, so a new sample is taken only once the
// previous one has run through the whole microprogram. The microprogram runs the
// three gain products and the level-times-step product one after another through a
// single shared 17 x 24 multiplier. A finished result waits in the output register
// while the next sample is taken; the last step stalls only if the previous result
// has still not been taken. Configuration is written with cfg_we, cfg_index and
// cfg_wdata and takes effect at once; indexes beyond the six registers are ignored.
module pid_differential_steering_core (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_we,
    input  wire logic [pds_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [pds_pkg::GAIN_W-1:0]             cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [pds_pkg::ERROR_WIDTH-1:0] s_position_error,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [pds_pkg::GAIN_W-1:0]                  m_left_speed,
    output logic [pds_pkg::GAIN_W-1:0]                  m_right_speed,
    output logic signed [pds_pkg::LEVEL_W-1:0]          m_turn_level,
    output logic                                        m_turn_right
);

    localparam int EW = pds_pkg::ERROR_WIDTH;
    localparam int SW = pds_pkg::SUM_WIDTH;
    localparam int GW = pds_pkg::GAIN_W;
    localparam int LW = pds_pkg::LEVEL_W;
    localparam int BW = pds_pkg::MUL_B_W;
    localparam int PW = pds_pkg::PROD_W;
    localparam int AW = pds_pkg::ACC_W;
    localparam int VW = pds_pkg::SPD_W;
    localparam int DW = pds_pkg::DIFF_W;

    localparam logic signed [AW-1:0] LIM =
        AW'(pds_pkg::LEVEL_LIMIT) << pds_pkg::GAIN_FRAC_BITS;
    localparam logic signed [SW-1:0] SUM_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SUM_MIN = {1'b1, {(SW-1){1'b0}}};

    // Configuration registers.
    logic [GW-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [GW-1:0] base_speed_reg, speed_step_reg, max_speed_reg;

    // Controller state.
    logic [pds_pkg::UPC_W-1:0] upc_reg, upc_next;
    pds_pkg::ctrl_word_t       ctrl;
    logic                      advance;

    // Datapath registers.
    logic signed [EW-1:0] err_reg;
    logic signed [SW-1:0] error_sum_reg, error_sum_next;
    logic signed [EW-1:0] prev_error_reg;
    logic signed [DW-1:0] prev_diff_reg, prev_diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [LW-1:0]        mag_reg, mag_next;
    logic                 pos_reg, pos_next;

    // Output registers.
    logic                 m_valid_reg, m_valid_next;
    logic [GW-1:0]        left_reg, left_next;
    logic [GW-1:0]        right_reg, right_next;
    logic signed [LW-1:0] level_reg, level_next;
    logic                 right_dir_reg;

    // Shared multiplier operands.
    logic [GW-1:0]        mul_a;
    logic signed [GW:0]   mul_a_s;
    logic signed [BW-1:0] mul_b;

    logic signed [AW-1:0] abs_acc;
    logic signed [SW:0]   sum_wide;
    logic [VW-1:0]        add_amt, base_ext, fast_full;

    assign ctrl = pds_pkg::ucode_rom(upc_reg);

    // Step counter; each step waits until its condition holds before moving on.
    always_comb begin
        unique case (ctrl.cond)
            pds_pkg::COND_IN_BEAT:  advance = s_valid;
            pds_pkg::COND_OUT_FREE: advance = !m_valid_reg || m_ready;
            pds_pkg::COND_ALWAYS:   advance = 1'b1;
            default:                advance = 1'b1;
        endcase
        upc_next = advance ? ctrl.next_addr : upc_reg;
    end

    assign s_ready = (ctrl.cond == pds_pkg::COND_IN_BEAT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= '0;
        end else begin
            upc_reg <= upc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= pds_pkg::RST_PROP_GAIN;
            integ_gain_reg <= pds_pkg::RST_INTEG_GAIN;
            deriv_gain_reg <= pds_pkg::RST_DERIV_GAIN;
            base_speed_reg <= pds_pkg::RST_BASE_SPEED;
            speed_step_reg <= pds_pkg::RST_SPEED_STEP;
            max_speed_reg  <= pds_pkg::RST_MAX_SPEED;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pds_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata;
                pds_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_wdata;
                pds_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata;
                pds_pkg::CFG_BASE_SPEED: base_speed_reg <= cfg_wdata;
                pds_pkg::CFG_SPEED_STEP: speed_step_reg <= cfg_wdata;
                pds_pkg::CFG_MAX_SPEED:  max_speed_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (ctrl.a_sel)
            pds_pkg::A_PROP:  mul_a = prop_gain_reg;
            pds_pkg::A_INTEG: mul_a = integ_gain_reg;
            pds_pkg::A_DERIV: mul_a = deriv_gain_reg;
            pds_pkg::A_STEP:  mul_a = speed_step_reg;
            default:          mul_a = prop_gain_reg;
        endcase
        unique case (ctrl.b_sel)
            pds_pkg::B_ERROR: mul_b = BW'(err_reg);
            pds_pkg::B_SUM:   mul_b = BW'(error_sum_reg);
            pds_pkg::B_DIFF:  mul_b = BW'(prev_diff_reg);
            pds_pkg::B_LEVEL: mul_b = BW'($signed({1'b0, mag_reg}));
            default:          mul_b = BW'(err_reg);
        endcase
        mul_a_s   = $signed({1'b0, mul_a});
        prod_next = PW'(mul_a_s * mul_b);
    end

    always_comb begin
        unique case (ctrl.acc_op)
            pds_pkg::ACC_LOAD: acc_next = AW'(prod_reg);
            pds_pkg::ACC_ADD:  acc_next = acc_reg + AW'(prod_reg);
            pds_pkg::ACC_HOLD: acc_next = acc_reg;
            default:           acc_next = acc_reg;
        endcase
    end

    // Clamp the control sum and truncate its magnitude toward zero.
    always_comb begin
        pos_next = !acc_reg[AW-1] && (acc_reg != '0);
        abs_acc  = pos_next ? acc_reg : -acc_reg;
        if (abs_acc > LIM) begin
            mag_next = LW'(pds_pkg::LEVEL_LIMIT);
        end else begin
            mag_next = abs_acc[pds_pkg::GAIN_FRAC_BITS +: LW];
        end
    end

    // Wheel speeds from the level-times-step product, then state update terms.
    always_comb begin
        add_amt   = prod_reg[VW-1:0];
        base_ext  = VW'(base_speed_reg);
        fast_full = base_ext + add_amt;
        if (fast_full > VW'(max_speed_reg)) begin
            fast_full = VW'(max_speed_reg);
        end
        if (pos_reg) begin
            left_next  = fast_full[GW-1:0];
            right_next = (add_amt > base_ext) ? '0 : GW'(base_ext - add_amt);
            level_next = $signed(mag_reg);
        end else begin
            left_next  = (add_amt > base_ext) ? '0 : GW'(base_ext - add_amt);
            right_next = fast_full[GW-1:0];
            level_next = $signed(LW'(-mag_reg));
        end

        prev_diff_next = DW'(err_reg) - DW'(prev_error_reg);
        sum_wide       = (SW+1)'(error_sum_reg) + (SW+1)'(err_reg);
        if (sum_wide[SW] != sum_wide[SW-1]) begin
            error_sum_next = sum_wide[SW] ? SUM_MIN : SUM_MAX;
        end else begin
            error_sum_next = sum_wide[SW-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.finish && advance) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            prev_diff_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (ctrl.finish && advance) begin
                error_sum_reg  <= error_sum_next;
                prev_error_reg <= err_reg;
                prev_diff_reg  <= prev_diff_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            err_reg <= s_position_error;
        end
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
        if (ctrl.level_en) begin
            mag_reg <= mag_next;
            pos_reg <= pos_next;
        end
        if (ctrl.finish && advance) begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            level_reg     <= level_next;
            right_dir_reg <= pos_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_speed  = left_reg;
    assign m_right_speed = right_reg;
    assign m_turn_level  = level_reg;
    assign m_turn_right  = right_dir_reg;

endmodule

`default_nettype wire

// ===== sim/pid_differential_steering_core_tb.sv =====
// Self-checking testbench for pid_differential_steering_core: error samples in, wheel
// commands out, each beat compared against a cycle-free model kept inside this file.
// Depends on pds_pkg and the core RTL only.
`timescale 1ns / 1ps

module pid_differential_steering_core_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 125;
    localparam logic [pds_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [pds_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam longint TURN_LIMIT =
        longint'(pds_pkg::LEVEL_LIMIT) << pds_pkg::GAIN_FRAC_BITS;
    localparam longint INTEG_MAX  = (longint'(1) << (pds_pkg::SUM_WIDTH - 1)) - 1;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;

    typedef struct packed {
        logic [pds_pkg::GAIN_W-1:0]  left_speed;
        logic [pds_pkg::GAIN_W-1:0]  right_speed;
        logic [pds_pkg::LEVEL_W-1:0] turn_level;
        logic                        turn_right;
    } wheel_cmd_t;

    logic                                   aclk = 1'b0;
    logic                                   aresetn = 1'b0;
    logic                                   cfg_we = 1'b0;
    logic [pds_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
    logic [pds_pkg::GAIN_W-1:0]             cfg_wdata = '0;
    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic signed [pds_pkg::ERROR_WIDTH-1:0] s_position_error = '0;
    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic [pds_pkg::GAIN_W-1:0]             m_left_speed;
    logic [pds_pkg::GAIN_W-1:0]             m_right_speed;
    logic signed [pds_pkg::LEVEL_W-1:0]     m_turn_level;
    logic                                   m_turn_right;

    // Model copy of the registers and the controller state.
    logic [pds_pkg::GAIN_W-1:0]             kp = pds_pkg::RST_PROP_GAIN;
    logic [pds_pkg::GAIN_W-1:0]             ki = pds_pkg::RST_INTEG_GAIN;
    logic [pds_pkg::GAIN_W-1:0]             kd = pds_pkg::RST_DERIV_GAIN;
    logic [pds_pkg::GAIN_W-1:0]             base_drive = pds_pkg::RST_BASE_SPEED;
    logic [pds_pkg::GAIN_W-1:0]             drive_step = pds_pkg::RST_SPEED_STEP;
    logic [pds_pkg::GAIN_W-1:0]             drive_ceiling = pds_pkg::RST_MAX_SPEED;
    logic signed [pds_pkg::SUM_WIDTH-1:0]   integ_acc = '0;
    logic signed [pds_pkg::ERROR_WIDTH-1:0] prior_sample = '0;
    logic signed [pds_pkg::DIFF_W-1:0]      last_delta = '0;

    wheel_cmd_t expected_cmds[$];
    int mismatches = 0;
    int stall_cycles = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    pid_differential_steering_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_position_error (s_position_error),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_speed     (m_left_speed),
        .m_right_speed    (m_right_speed),
        .m_turn_level     (m_turn_level),
        .m_turn_right     (m_turn_right)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Computes the command for one error sample, then advances the controller state.
    task automatic predict_wheel_cmd(input logic signed [pds_pkg::ERROR_WIDTH-1:0] err);
        longint ctrl, level, add, fast, slow, delta, next_integ;
        wheel_cmd_t cmd;
        ctrl = longint'(kp) * longint'(err) + longint'(ki) * longint'(integ_acc)
             + longint'(kd) * longint'(last_delta);
        if (ctrl > 0) begin
            level = ((ctrl > TURN_LIMIT) ? TURN_LIMIT : ctrl) >>> pds_pkg::GAIN_FRAC_BITS;
            add = level * longint'(drive_step);
        end else begin
            level = -(((ctrl < -TURN_LIMIT) ? TURN_LIMIT : -ctrl)
                      >>> pds_pkg::GAIN_FRAC_BITS);
            add = -level * longint'(drive_step);
        end
        fast = longint'(base_drive) + add;
        if (fast > longint'(drive_ceiling)) fast = longint'(drive_ceiling);
        slow = longint'(base_drive) - add;
        if (slow < 0) slow = 0;
        cmd.turn_right  = (ctrl > 0);
        cmd.left_speed  = cmd.turn_right ? fast[pds_pkg::GAIN_W-1:0]
                                         : slow[pds_pkg::GAIN_W-1:0];
        cmd.right_speed = cmd.turn_right ? slow[pds_pkg::GAIN_W-1:0]
                                         : fast[pds_pkg::GAIN_W-1:0];
        cmd.turn_level  = level[pds_pkg::LEVEL_W-1:0];
        expected_cmds.push_back(cmd);

        delta = longint'(err) - longint'(prior_sample);
        last_delta = delta[pds_pkg::DIFF_W-1:0];
        prior_sample = err;
        next_integ = longint'(integ_acc) + longint'(err);
        if (next_integ > INTEG_MAX) next_integ = INTEG_MAX;
        if (next_integ < INTEG_MIN) next_integ = INTEG_MIN;
        integ_acc = next_integ[pds_pkg::SUM_WIDTH-1:0];
    endtask

    task automatic write_reg(input logic [pds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pds_pkg::GAIN_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        case (idx)
            pds_pkg::CFG_PROP_GAIN:  kp = value;
            pds_pkg::CFG_INTEG_GAIN: ki = value;
            pds_pkg::CFG_DERIV_GAIN: kd = value;
            pds_pkg::CFG_BASE_SPEED: base_drive = value;
            pds_pkg::CFG_SPEED_STEP: drive_step = value;
            pds_pkg::CFG_MAX_SPEED:  drive_ceiling = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic write_gains(input logic [pds_pkg::GAIN_W-1:0] p,
                               input logic [pds_pkg::GAIN_W-1:0] i,
                               input logic [pds_pkg::GAIN_W-1:0] d);
        write_reg(pds_pkg::CFG_PROP_GAIN, p);
        write_reg(pds_pkg::CFG_INTEG_GAIN, i);
        write_reg(pds_pkg::CFG_DERIV_GAIN, d);
    endtask

    task automatic write_drive(input logic [pds_pkg::GAIN_W-1:0] base,
                               input logic [pds_pkg::GAIN_W-1:0] step,
                               input logic [pds_pkg::GAIN_W-1:0] ceiling);
        write_reg(pds_pkg::CFG_BASE_SPEED, base);
        write_reg(pds_pkg::CFG_SPEED_STEP, step);
        write_reg(pds_pkg::CFG_MAX_SPEED, ceiling);
    endtask

    // Returns right after the beat is taken; valid is left high until the next call
    // or drain decides at the following falling edge.
    task automatic send_error(input logic signed [pds_pkg::ERROR_WIDTH-1:0] err);
        logic [31:0] junk;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            junk = $urandom;
            s_valid = 1'b0;
            s_position_error = junk[pds_pkg::ERROR_WIDTH-1:0];
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_position_error = err;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_wheel_cmd(err);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [pds_pkg::ERROR_WIDTH-1:0] pick_error();
        int v;
        logic [31:0] raw;
        raw = $urandom;
        if ($urandom_range(0, 99) < 40) begin
            v = $urandom_range(0, 12);
            v = v - 6;
            return v[pds_pkg::ERROR_WIDTH-1:0];
        end
        return raw[pds_pkg::ERROR_WIDTH-1:0];
    endfunction

    function automatic logic [pds_pkg::GAIN_W-1:0] pick_setting(input int typical);
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return raw[pds_pkg::GAIN_W-1:0];
            default: begin
                raw = $urandom_range(0, typical);
                return raw[pds_pkg::GAIN_W-1:0];
            end
        endcase
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_wheel_beats
        wheel_cmd_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat: expected none, actual %0d/%0d/%0d/%0d",
                             $time, m_left_speed, m_right_speed, $signed(m_turn_level),
                             m_turn_right);
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("left_speed", longint'(want.left_speed),
                                longint'(m_left_speed));
                    check_field("right_speed", longint'(want.right_speed),
                                longint'(m_right_speed));
                    check_field("turn_level", longint'($signed(want.turn_level)),
                                longint'(m_turn_level));
                    check_field("turn_right", longint'(want.turn_right),
                                longint'(m_turn_right));
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // Extremes of the error field under the reset gains, both turn directions.
    task automatic test_reset_settings();
        send_error(8'sd0);
        send_error(8'sd1);
        send_error(-8'sd1);
        send_error(8'sd127);
        send_error(-8'sd128);
        send_error(8'sd64);
        send_error(8'sd3);
        wait_results_drained();
    endtask

    task automatic test_register_extremes();
        // Zero gains give a zero sum: straight ahead, faster side held to the ceiling.
        write_gains(16'd0, 16'd0, 16'd0);
        write_reg(pds_pkg::CFG_MAX_SPEED, 16'd15000);
        send_error(8'sd5);
        wait_results_drained();
        // Writes to unmapped indexes must leave every register alone.
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        send_error(-8'sd7);
        wait_results_drained();

        write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_drive(16'd0, 16'hFFFF, 16'hFFFF);
        send_error(8'sd127);
        send_error(-8'sd128);
        wait_results_drained();

        write_drive(16'hFFFF, 16'd0, 16'hFFFF);
        send_error(-8'sd1);
        send_error(8'sd1);
        wait_results_drained();

        write_drive(16'hFFFF, 16'hFFFF, 16'd0);
        send_error(8'sd100);
        send_error(-8'sd100);
        wait_results_drained();

        // A sum just below one level truncates to zero but still reports a right turn.
        write_gains(16'd4095, 16'd0, 16'd0);
        write_drive(pds_pkg::RST_BASE_SPEED, pds_pkg::RST_SPEED_STEP,
                    pds_pkg::RST_MAX_SPEED);
        send_error(8'sd1);
        send_error(-8'sd1);
        send_error(8'sd4);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int src_idle, input int sink_stall);
        logic [31:0] raw;
        src_idle_pct = src_idle;
        sink_stall_pct = sink_stall;
        for (int half = 0; half < 2; half++) begin
            write_gains(pick_setting(8192), pick_setting(64), pick_setting(8192));
            write_drive(pick_setting(40000), pick_setting(20000), pick_setting(65535));
            if ($urandom_range(0, 1) == 1) begin
                raw = $urandom;
                write_reg(raw[0] ? CFG_SPARE_HI : CFG_SPARE_LO, raw[pds_pkg::GAIN_W:1]);
            end
            for (int n = 0; n < ITEMS_PER_SETTING; n++) send_error(pick_error());
            wait_results_drained();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_register_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(58, 0);
        test_random_traffic(0, 58);
        test_random_traffic(32, 32);

        wait_results_drained();
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
